// File: hw/rtl/aap_pkg.sv
// Shared types and constants for the all-pairs box overlap block.
// No dependencies; imported by every module of the block.
package aap_pkg;

   localparam int COORD_W = 20;
   localparam int EXTENT_W = 16;
   localparam int ID_W = 16;
   // edge sums: 20-bit signed plus 16-bit unsigned fits in 21 signed bits
   localparam int SUM_W = 21;
   localparam int HIT_W = 6;
   localparam logic [HIT_W-1:0] RESULT_LIMIT = 6'd63;

   typedef struct packed {
      logic        [EXTENT_W-1:0] box_height;
      logic        [EXTENT_W-1:0] box_width;
      logic signed [COORD_W-1:0]  y_pos;
      logic signed [COORD_W-1:0]  x_pos;
      logic        [ID_W-1:0]     entity_id;
   } box_type;

endpackage

// File: hw/rtl/aap_cell.sv
// One storage cell of the box ring: holds a single stored box.
// Depends on aap_pkg for box_type.
module aap_cell
   import aap_pkg::*;
(
   input  logic    clock,
   input  logic    advance,
   input  box_type d_in,
   output box_type q
);

   box_type entry_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= d_in;
      end
   end

   assign q = entry_ff;

endmodule

// File: hw/rtl/aap_overlap.sv
// Strict-inequality overlap test between a stored box and the query box.
// Depends on aap_pkg for box_type and widths.
module aap_overlap
   import aap_pkg::*;
(
   input  box_type stored,
   input  box_type query,
   output logic    overlap
);

   logic signed [SUM_W-1:0] sx, sy, qx, qy;
   logic signed [SUM_W-1:0] sx_end, sy_end, qx_end, qy_end;

   always_comb begin
      sx = SUM_W'(stored.x_pos);
      sy = SUM_W'(stored.y_pos);
      qx = SUM_W'(query.x_pos);
      qy = SUM_W'(query.y_pos);
      sx_end = sx + $signed({{(SUM_W-EXTENT_W){1'b0}}, stored.box_width});
      sy_end = sy + $signed({{(SUM_W-EXTENT_W){1'b0}}, stored.box_height});
      qx_end = qx + $signed({{(SUM_W-EXTENT_W){1'b0}}, query.box_width});
      qy_end = qy + $signed({{(SUM_W-EXTENT_W){1'b0}}, query.box_height});
      overlap = (sx < qx_end) && (sx_end > qx) && (sy < qy_end) && (sy_end > qy);
   end

endmodule

// File: hw/rtl/aabb_all_pairs_overlap.sv
// Top level of the all-pairs box overlap block: sequencer, ring of cells, result register.
// Depends on aap_pkg, aap_cell and aap_overlap.
//
//   channel | dir | tdata                          | tuser     | tlast
//   req     | in  | id, x, y, width, height (88b)  | new_frame | -
//   rsp     | out | first_entity, second_entity    | -         | last_in_run
//
// Each item is accepted, then swept with one ring rotation step per cell (the stored boxes
// circle past one comparator at the ring head), then finished in a flush state.
// A result stall holds the rotation only when a second overlap needs the output.
// Reset clears the fill count and control; cell contents are unknown until written.
// req_tready is high only between items; a held result that cannot enter a busy output blocks the next item.
module aabb_all_pairs_overlap
   import aap_pkg::*;
#(
   parameter int BOX_CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,  // entity_id, x_pos, y_pos, box_width, box_height
   input  logic [0:0]  req_tuser,  // new_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // first_entity, second_entity
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(BOX_CAPACITY + 1);
   localparam int STEP_W = $clog2(BOX_CAPACITY);
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(BOX_CAPACITY);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BOX_CAPACITY - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_FLUSH} state_type;

   state_type          state_ff, state_in;
   box_type            query_ff, query_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [HIT_W-1:0]   hits_ff, hits_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic    ring_advance;
   logic    overlap, hit, out_free, store_slot;
   box_type write_back;
   box_type ring [BOX_CAPACITY];

   // ring: cell 0 is the head; data moves toward the head, tail refills
   for (genvar g = 0; g < BOX_CAPACITY; g++) begin : g_ring
      if (g == BOX_CAPACITY - 1) begin : g_tail
         aap_cell u_cell (.clock(clock), .advance(ring_advance), .d_in(write_back),
                          .q(ring[g]));
      end else begin : g_body
         aap_cell u_cell (.clock(clock), .advance(ring_advance), .d_in(ring[g+1]),
                          .q(ring[g]));
      end
   end

   aap_overlap u_overlap (.stored(ring[0]), .query(query_ff), .overlap(overlap));

   assign store_slot = (CNT_W'(step_ff) == count_ff) && (count_ff != CAP_C);
   assign write_back = store_slot ? query_ff : ring[0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign hit = (state_ff == ST_SWEEP) && (CNT_W'(step_ff) < count_ff) &&
                (hits_ff != RESULT_LIMIT) && (ring[0].entity_id != query_ff.entity_id) &&
                overlap;

   always_comb begin
      state_in = state_ff;
      query_in = query_ff;
      count_in = count_ff;
      step_in = step_ff;
      hits_in = hits_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in = pend_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      ring_advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               query_in = req_tdata;
               if (req_tuser[0]) begin
                  count_in = '0;
               end
               step_in = '0;
               hits_in = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // hold only when an earlier hit must leave and the output is busy
            if (!(hit && pend_valid_ff && !out_free)) begin
               ring_advance = 1'b1;
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in = {query_ff.entity_id, pend_id_ff};
                     rsp_last_in = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in = ring[0].entity_id;
                  hits_in = hits_ff + 1'b1;
               end
               if (step_ff == LAST_STEP) begin
                  step_in = '0;
                  state_in = ST_FLUSH;
                  if (count_ff != CAP_C) begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {query_ff.entity_id, pend_id_ff};
               rsp_last_in = 1'b1;
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      query_ff <= query_in;
      step_ff <= step_in;
      hits_ff <= hits_in;
      pend_id_ff <= pend_id_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("fill count beyond capacity");

   a_no_pending_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("held result left behind between items");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready during sweep");

   a_limit_marks_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && hits_ff == RESULT_LIMIT) |-> pend_valid_ff)
      else $error("result limit reached without held result");

endmodule
